@@ src/kvle_pkg.sv @@
// Package: shared constants, register indexes and result type for the key/value line extractor
`timescale 1ns / 1ps
package kvle_pkg;

    localparam int MAX_KEY_BYTES_DEF = 8;

    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 64;
    localparam int KLEN_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    localparam logic [KLEN_W-1:0] KEY_LENGTH_RST  = 4'd1;
    localparam logic [BYTE_W-1:0] VALUE_LIMIT_RST = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] value_byte;
        logic              byte_valid;
        logic              found;
        logic              last;
    } t_result;

endpackage

@@ src/kvle_step.sv @@
// Line parser: per-byte key compare, value emission and parse state
`timescale 1ns / 1ps
module kvle_step #(
    parameter int MAX_KEY_BYTES = kvle_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [kvle_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic [MAX_KEY_BYTES*8-1:0]      i_key_bytes,
    input  logic [kvle_pkg::KLEN_W-1:0]     i_key_length,
    input  logic [kvle_pkg::BYTE_W-1:0]     i_value_limit,
    output kvle_pkg::t_result               o_res
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [1:0] {
        MODE_MATCH,
        MODE_SKIP,
        MODE_VALUE,
        MODE_DONE
    } t_mode;

    t_mode                          r_mode, n_mode;
    logic [kvle_pkg::KLEN_W-1:0]    r_pos, n_pos;
    logic [kvle_pkg::BYTE_W-1:0]    r_count, n_count;

    logic [kvle_pkg::KLEN_W-1:0]    len;
    logic [KIDX_W-1:0]              pos_idx;
    logic [kvle_pkg::BYTE_W-1:0]    key_char;
    logic                           is_nul;

    assign len = (i_key_length > kvle_pkg::KLEN_W'(MAX_KEY_BYTES))
               ? kvle_pkg::KLEN_W'(MAX_KEY_BYTES) : i_key_length;
    assign pos_idx  = r_pos[KIDX_W-1:0];
    assign key_char = i_key_bytes[pos_idx*8 +: 8];
    assign is_nul   = (i_text_byte == kvle_pkg::CH_NUL);

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_count = r_count;
        o_res   = '0;
        case (r_mode)
            MODE_MATCH: begin
                if (is_nul) begin
                    n_mode     = MODE_MATCH;
                    n_pos      = '0;
                    n_count    = '0;
                    o_res.valid = 1'b1;
                    o_res.last  = 1'b1;
                end else if (len != '0 && r_pos < len && i_text_byte == key_char) begin
                    n_pos = kvle_pkg::KLEN_W'(r_pos + 1'b1);
                end else if (len != '0 && r_pos >= len && i_text_byte == kvle_pkg::CH_EQ) begin
                    n_mode  = MODE_VALUE;
                    n_pos   = '0;
                    n_count = '0;
                end else begin
                    n_pos  = '0;
                    n_mode = (i_text_byte == kvle_pkg::CH_NL) ? MODE_MATCH : MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                if (is_nul) begin
                    n_mode      = MODE_MATCH;
                    n_pos       = '0;
                    n_count     = '0;
                    o_res.valid = 1'b1;
                    o_res.last  = 1'b1;
                end else if (i_text_byte == kvle_pkg::CH_NL) begin
                    n_mode = MODE_MATCH;
                    n_pos  = '0;
                end
            end
            MODE_VALUE: begin
                if (is_nul || i_text_byte == kvle_pkg::CH_NL) begin
                    if (is_nul) begin
                        n_mode  = MODE_MATCH;
                        n_pos   = '0;
                        n_count = '0;
                    end else begin
                        n_mode = MODE_DONE;
                    end
                    o_res.valid = 1'b1;
                    o_res.found = 1'b1;
                    o_res.last  = 1'b1;
                end else if (r_count < i_value_limit) begin
                    n_count          = kvle_pkg::BYTE_W'(r_count + 1'b1);
                    o_res.valid      = 1'b1;
                    o_res.value_byte = i_text_byte;
                    o_res.byte_valid = 1'b1;
                end
            end
            default: begin
                if (is_nul) begin
                    n_mode  = MODE_MATCH;
                    n_pos   = '0;
                    n_count = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MATCH;
            r_pos   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

endmodule

@@ src/kvle_obuf.sv @@
// Output register: holds one result until the downstream side takes it
`timescale 1ns / 1ps
module kvle_obuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  kvle_pkg::t_result           i_res,
    input  logic                        i_out_ready,
    output logic                        o_space,
    output logic                        o_out_valid,
    output logic [kvle_pkg::BYTE_W-1:0] o_value_byte,
    output logic                        o_byte_valid,
    output logic                        o_found,
    output logic                        o_last
);

    logic                        r_valid;
    logic [kvle_pkg::BYTE_W-1:0] r_value_byte;
    logic                        r_byte_valid;
    logic                        r_found;
    logic                        r_last;

    assign o_space = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load && i_res.valid) begin
            r_value_byte <= i_res.value_byte;
            r_byte_valid <= i_res.byte_valid;
            r_found      <= i_res.found;
            r_last       <= i_res.last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_value_byte = r_value_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_found      = r_found;
    assign o_last       = r_last;

endmodule

@@ src/key_value_line_extract.sv @@
// Top level: configuration registers, line parser and output register
// Timing: a result is registered and appears in the output register in the cycle after its byte is taken.
// Throughput: one text byte per cycle; the single output register sets the pace,
// and a byte is taken whenever that register is empty or being emptied.
// Reset: synchronous active low; parser returns to line start, registers to defaults.
`timescale 1ns / 1ps
module key_value_line_extract #(
    parameter int MAX_KEY_BYTES = kvle_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kvle_pkg::BYTE_W-1:0]     i_text_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [kvle_pkg::BYTE_W-1:0]     o_value_byte,
    output logic                            o_byte_valid,
    output logic                            o_found,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kvle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kvle_pkg::KEY_W-1:0]      i_cfg_data
);

    localparam int KEY_STORE_W = MAX_KEY_BYTES * 8;

    logic [KEY_STORE_W-1:0]         r_key_bytes;
    logic [kvle_pkg::KLEN_W-1:0]    r_key_length;
    logic [kvle_pkg::BYTE_W-1:0]    r_value_limit;

    kvle_pkg::t_result              step_res;
    logic                           space;
    logic                           in_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign in_take     = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes   <= '0;
            r_key_length  <= kvle_pkg::KEY_LENGTH_RST;
            r_value_limit <= kvle_pkg::VALUE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kvle_pkg::CFG_KEY_BYTES:   r_key_bytes   <= i_cfg_data[KEY_STORE_W-1:0];
                kvle_pkg::CFG_KEY_LENGTH:  r_key_length  <= i_cfg_data[kvle_pkg::KLEN_W-1:0];
                kvle_pkg::CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data[kvle_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kvle_step #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_take),
        .i_text_byte  (i_text_byte),
        .i_key_bytes  (r_key_bytes),
        .i_key_length (r_key_length),
        .i_value_limit(r_value_limit),
        .o_res        (step_res)
    );

    kvle_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_in_valid),
        .i_res       (step_res),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_value_byte(o_value_byte),
        .o_byte_valid(o_byte_valid),
        .o_found     (o_found),
        .o_last      (o_last)
    );

`ifndef ASSERT_OFF
    a_char_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> !o_last)
        else $error("value character marked last");

    a_found_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_last && !o_byte_valid))
        else $error("found flag outside final request");

    a_nul_closes_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_text_byte == kvle_pkg::CH_NUL) |=> (o_out_valid && o_last)
        || (o_out_valid == 1'b0 && $past(u_step.o_res.valid) == 1'b0))
        else $error("end of text gave no final request");
`endif

endmodule
